>>> hdl/lfs_pkg.sv
// Shared types, byte codes and field length constants for the log field splitter.
// No dependencies; every other file in the project imports this package.
package lfs_pkg;

    // Longest field length that is counted before the count saturates.
    localparam int MAX_FIELD_LEN = 4096;
    localparam int LEN_W         = $clog2(MAX_FIELD_LEN + 1);
    localparam int FIELD_LEN_W   = 13;

    localparam logic [7:0] BYTE_ESC      = 8'h5C;
    localparam logic [7:0] BYTE_QUOTE    = 8'h22;
    localparam logic [7:0] BYTE_LBRACK   = 8'h5B;
    localparam logic [7:0] BYTE_RBRACK   = 8'h5D;
    localparam logic [7:0] DELIM_DEFAULT = 8'h20;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_QUOTE   = 2'd1,
        MODE_BRACKET = 2'd2
    } t_span_mode;

    // Tokenizer state carried from one byte to the next.
    typedef struct packed {
        logic             escape_pending;
        t_span_mode       span_mode;
        logic [LEN_W-1:0] pending_length;
    } t_state;

    // Per-byte result flags and length.
    typedef struct packed {
        logic                   keep;
        logic                   field_done;
        logic [FIELD_LEN_W-1:0] field_length;
    } t_result;

endpackage

>>> hdl/lfs_step.sv
// Combinational next-state and result logic for one byte of the splitter.
// Depends on lfs_pkg for the state and result types and the byte codes.
module lfs_step (
    input  lfs_pkg::t_state  i_state,
    input  logic [7:0]       i_delimiter,
    input  logic [7:0]       i_byte,
    input  logic             i_eol,
    output lfs_pkg::t_state  o_next,
    output lfs_pkg::t_result o_result
);
    import lfs_pkg::*;

    logic             is_esc;
    logic             is_quote;
    logic             is_lbrack;
    logic             is_closer;
    logic             is_delim;
    logic             keep;
    logic             close_now;
    logic             clear_len;
    logic [LEN_W-1:0] close_len;
    logic [LEN_W-1:0] base_len;
    logic [LEN_W-1:0] after_len;
    t_span_mode       mode_after;
    logic [31:0]      len_wide;

    // Byte classification against the fixed codes and the delimiter.
    always_comb begin
        is_esc    = (i_byte == BYTE_ESC);
        is_quote  = (i_byte == BYTE_QUOTE);
        is_lbrack = (i_byte == BYTE_LBRACK);
        is_delim  = (i_byte == i_delimiter);
        unique case (i_state.span_mode)
            MODE_QUOTE:   is_closer = is_quote;
            MODE_BRACKET: is_closer = (i_byte == BYTE_RBRACK);
            default:      is_closer = 1'b0;
        endcase
    end

    // Span mode and field closing decision, in priority order.
    always_comb begin
        keep       = 1'b0;
        close_now  = 1'b0;
        clear_len  = 1'b0;
        mode_after = i_state.span_mode;
        if (i_state.escape_pending) begin
            keep = 1'b1;
        end else if (is_esc) begin
            keep = 1'b1;
        end else if (i_state.span_mode == MODE_QUOTE || i_state.span_mode == MODE_BRACKET) begin
            if (is_closer) begin
                close_now  = 1'b1;
                clear_len  = 1'b1;
                mode_after = MODE_PLAIN;
            end else begin
                keep = 1'b1;
            end
        end else begin
            mode_after = MODE_PLAIN;
            if (is_quote) begin
                mode_after = MODE_QUOTE;
            end else if (is_lbrack) begin
                mode_after = MODE_BRACKET;
            end else if (is_delim) begin
                close_now = (i_state.pending_length != '0);
                clear_len = 1'b1;
            end else begin
                keep = 1'b1;
            end
        end
    end

    // Length bookkeeping with saturation at the maximum field length.
    always_comb begin
        base_len = clear_len ? '0 : i_state.pending_length;
        if (!keep) begin
            after_len = base_len;
        end else if (base_len < LEN_W'(MAX_FIELD_LEN)) begin
            after_len = base_len + LEN_W'(1);
        end else begin
            after_len = LEN_W'(MAX_FIELD_LEN);
        end
    end

    // Next state: the end of a line returns everything to reset.
    always_comb begin
        if (i_eol) begin
            o_next.escape_pending = 1'b0;
            o_next.span_mode      = MODE_PLAIN;
            o_next.pending_length = '0;
        end else begin
            o_next.escape_pending = !i_state.escape_pending && is_esc;
            o_next.span_mode      = mode_after;
            o_next.pending_length = after_len;
        end
    end

    // Result: a field closed by this byte wins over the end-of-line flush.
    always_comb begin
        if (close_now) begin
            close_len = i_state.pending_length;
        end else if (i_eol) begin
            close_len = after_len;
        end else begin
            close_len = '0;
        end
        len_wide              = 32'(close_len);
        o_result.keep         = keep;
        o_result.field_done   = close_now || (i_eol && after_len != '0);
        o_result.field_length = len_wide[FIELD_LEN_W-1:0];
    end

endmodule

>>> hdl/log_field_splitter.sv
// Log field splitter: one byte of a log line in, one tagged byte out.
// An accepted request's result appears on the output register in the next cycle.
// Throughput is one byte per cycle; the output register holds a stalled result
// while the next byte waits at the input, so a stall reaches the input at once.
// Synchronous active-low reset clears the span state, the length count and the
// output valid, and sets the delimiter to a space.
module log_field_splitter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [7:0]                      i_cfg_data,
    output logic                            o_cfg_ready,
    input  logic                            i_in_valid,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_end_of_line,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output logic [7:0]                      o_out_byte,
    output logic                            o_keep,
    output logic                            o_field_done,
    output logic [lfs_pkg::FIELD_LEN_W-1:0] o_field_length,
    output logic                            o_line_done,
    input  logic                            i_out_stall
);
    import lfs_pkg::*;

    logic       cfg_write;
    logic [7:0] r_delimiter;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    t_result    r_result;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_line_done;
    logic       in_accept;

    assign o_cfg_ready     = 1'b1;
    assign cfg_write       = i_cfg_valid && o_cfg_ready;
    assign o_in_stall      = r_out_valid && i_out_stall;
    assign in_accept       = i_in_valid && !o_in_stall;

    // Delimiter configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delimiter <= DELIM_DEFAULT;
        end else if (cfg_write) begin
            r_delimiter <= i_cfg_data;
        end
    end

    lfs_step u_step (
        .i_state     (r_state),
        .i_delimiter (r_delimiter),
        .i_byte      (i_in_byte),
        .i_eol       (i_end_of_line),
        .o_next      (n_state),
        .o_result    (n_result)
    );

    // Tokenizer state advances on every accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.escape_pending <= 1'b0;
            r_state.span_mode      <= MODE_PLAIN;
            r_state.pending_length <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= i_in_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_byte  <= i_in_byte;
            r_line_done <= i_end_of_line;
            r_result    <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_keep         = r_result.keep;
    assign o_field_done   = r_result.field_done;
    assign o_field_length = r_result.field_length;
    assign o_line_done    = r_line_done;

endmodule

>>> hdl/lfs_checker.sv
// Port-level assertions for the log field splitter and the bind that attaches them.
// Depends on lfs_pkg and on the log_field_splitter top level.
module lfs_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_end_of_line,
    input  logic                            o_in_stall,
    input  logic                            o_out_valid,
    input  logic [7:0]                      o_out_byte,
    input  logic                            o_keep,
    input  logic                            o_field_done,
    input  logic [lfs_pkg::FIELD_LEN_W-1:0] o_field_length,
    input  logic                            o_line_done,
    input  logic                            i_out_stall
);
    import lfs_pkg::*;

    // An accepted request shows up on the output in the next cycle.
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid && o_out_byte == $past(i_in_byte)
            && o_line_done == $past(i_end_of_line))
        else $error("accepted request did not reach the output register");

    // A stalled result holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_keep) && $stable(o_field_done) && $stable(o_field_length))
        else $error("stalled result changed");

    // No length is reported unless a field closes.
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_field_done |-> o_field_length == '0)
        else $error("field length set without a closed field");

    // A field that closes at the end of a line is never reported without content
    // unless the byte is a closer, which is never kept.
    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_field_done && o_keep |-> o_field_length != '0)
        else $error("flushed field reported as empty");

endmodule

bind log_field_splitter lfs_checker u_lfs_checker (.*);

>>> tb/tb_log_field_splitter.sv
// Self-checking testbench for log_field_splitter: drives byte requests with random gaps and
// output stalls, predicts each tagged byte and compares it field by field.
// Depends on lfs_pkg and the log_field_splitter top level.
`timescale 1ns / 100ps

module tb_log_field_splitter;
    import lfs_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 145;

    // One byte of a line as it is queued for the driver.
    typedef struct packed {
        logic [7:0] data;
        logic       eol;
    } t_line_byte;

    // One predicted output request.
    typedef struct packed {
        logic [7:0]             out_byte;
        logic                   keep;
        logic                   field_done;
        logic [FIELD_LEN_W-1:0] field_length;
        logic                   line_done;
    } t_tagged_byte;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_cfg_valid    = 1'b0;
    logic [7:0]             i_cfg_data     = 8'h00;
    logic                   o_cfg_ready;
    logic                   i_in_valid     = 1'b0;
    logic [7:0]             i_in_byte      = 8'h00;
    logic                   i_end_of_line  = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [7:0]             o_out_byte;
    logic                   o_keep;
    logic                   o_field_done;
    logic [FIELD_LEN_W-1:0] o_field_length;
    logic                   o_line_done;
    logic                   i_out_stall    = 1'b0;

    // Stimulus and scoreboard storage.
    t_line_byte   line_q[$];
    t_tagged_byte tagged_q[$];
    t_line_byte   next_byte;
    t_tagged_byte want;
    int           queued_count   = 0;
    int           accepted_count = 0;
    int           cfg_count      = 0;
    int           mismatches     = 0;
    int           cycle_count    = 0;
    int           gap_left       = 0;
    int           stall_left     = 0;
    bit           in_taken       = 1'b0;
    bit           out_taken      = 1'b0;
    bit           idle_on        = 1'b1;
    logic [7:0]   gen_delim      = DELIM_DEFAULT;

    // Predictor state, a private copy of the tokenizer and its delimiter register.
    logic         esc_pend  = 1'b0;
    t_span_mode   span      = MODE_PLAIN;
    int           field_len = 0;
    logic [7:0]   pred_delim = DELIM_DEFAULT;

    log_field_splitter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_in_valid     (i_in_valid),
        .i_in_byte      (i_in_byte),
        .i_end_of_line  (i_end_of_line),
        .o_in_stall     (o_in_stall),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_keep         (o_keep),
        .o_field_done   (o_field_done),
        .o_field_length (o_field_length),
        .o_line_done    (o_line_done),
        .i_out_stall    (i_out_stall)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predict the tagged byte for one accepted request and advance the predictor state.
    function automatic t_tagged_byte split_byte(input logic [7:0] b, input logic eol);
        t_tagged_byte r;
        logic [7:0]   closer;
        r          = '0;
        r.out_byte  = b;
        r.line_done = eol;
        if (esc_pend) begin
            esc_pend = 1'b0;
            r.keep   = 1'b1;
        end else if (b == BYTE_ESC) begin
            esc_pend = 1'b1;
            r.keep   = 1'b1;
        end else if (span == MODE_QUOTE || span == MODE_BRACKET) begin
            closer = (span == MODE_QUOTE) ? BYTE_QUOTE : BYTE_RBRACK;
            if (b == closer) begin
                r.field_done   = 1'b1;
                r.field_length = field_len[FIELD_LEN_W-1:0];
                field_len      = 0;
                span           = MODE_PLAIN;
            end else begin
                r.keep = 1'b1;
            end
        end else if (b == BYTE_QUOTE) begin
            span = MODE_QUOTE;
        end else if (b == BYTE_LBRACK) begin
            span = MODE_BRACKET;
        end else if (b == pred_delim) begin
            // An empty plain field yields nothing.
            if (field_len != 0) begin
                r.field_done   = 1'b1;
                r.field_length = field_len[FIELD_LEN_W-1:0];
            end
            field_len = 0;
        end else begin
            r.keep = 1'b1;
        end

        if (r.keep && field_len < MAX_FIELD_LEN) field_len++;

        // The last byte of the line flushes pending content, even an unclosed span.
        if (eol) begin
            if (!r.field_done && field_len != 0) begin
                r.field_done   = 1'b1;
                r.field_length = field_len[FIELD_LEN_W-1:0];
            end
            esc_pend  = 1'b0;
            span      = MODE_PLAIN;
            field_len = 0;
        end
        return r;
    endfunction

    // Wait before the next request on either side, drawn at random; no wait during a burst.
    function automatic int idle_draw();
        return idle_on ? $urandom_range(0, 6) : 0;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
        end
    endtask

    // Input side: record accepted requests and predict their results.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            esc_pend   = 1'b0;
            span       = MODE_PLAIN;
            field_len  = 0;
            pred_delim = DELIM_DEFAULT;
            in_taken   = 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                pred_delim = i_cfg_data;
                cfg_count++;
            end
            in_taken = i_in_valid && !o_in_stall;
            if (in_taken) begin
                tagged_q.insert(tagged_q.size(), split_byte(i_in_byte, i_end_of_line));
                accepted_count++;
            end
        end
    end

    // Input side: present the next queued byte after its drawn gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (line_q.size() != 0) begin
                next_byte = line_q.pop_front();
                i_in_byte     <= next_byte.data;
                i_end_of_line <= next_byte.eol;
                i_in_valid    <= 1'b1;
                gap_left = idle_draw();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        cycle_count++;
        if (!i_rst_n) begin
            out_taken = 1'b0;
        end else begin
            out_taken = o_out_valid && !i_out_stall;
            if (out_taken) begin
                if (tagged_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual byte %0d",
                             $time, o_out_byte);
                end else begin
                    want = tagged_q.pop_front();
                    check_field("out_byte", 16'(want.out_byte), 16'(o_out_byte));
                    check_field("keep", 16'(want.keep), 16'(o_keep));
                    check_field("field_done", 16'(want.field_done), 16'(o_field_done));
                    check_field("field_length", 16'(want.field_length),
                                16'(o_field_length));
                    check_field("line_done", 16'(want.line_done), 16'(o_line_done));
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, tagged_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Output side: hold off each result for a drawn number of cycles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (out_taken) stall_left = idle_draw();
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic push_item(input logic [7:0] b, input logic eol);
        t_line_byte e;
        e.data = b;
        e.eol  = eol;
        line_q.insert(line_q.size(), e);
        queued_count++;
    endtask

    // Wait until every queued request has come back, then let the pipeline settle.
    task automatic wait_idle();
        while (accepted_count != queued_count || tagged_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Delimiter writes happen only while the block is idle.
    task automatic write_delim(input logic [7:0] d);
        int start;
        start = cfg_count;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= d;
        while (cfg_count == start) @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        gen_delim = d;
    endtask

    // Content byte that has no special meaning under the current delimiter.
    function automatic logic [7:0] plain_byte();
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255));
        while (v == gen_delim || v == BYTE_ESC || v == BYTE_QUOTE || v == BYTE_LBRACK);
        return v;
    endfunction

    // Random byte with the special codes drawn often.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 9))
            0: return gen_delim;
            1: return BYTE_ESC;
            2: return BYTE_QUOTE;
            3: return BYTE_LBRACK;
            4: return BYTE_RBRACK;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Build one mostly well-formed line of plain, quoted and bracketed fields.
    task automatic queue_line();
        logic [7:0] line[$];
        logic [7:0] closer;
        logic [7:0] v;
        int         nf;
        int         n;
        int         cut;
        nf = $urandom_range(1, 6);
        for (int f = 0; f < nf; f++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    n = $urandom_range(1, 8);
                    repeat (n) begin
                        if ($urandom_range(0, 7) == 0) begin
                            line.insert(line.size(), BYTE_ESC);
                            line.insert(line.size(), 8'($urandom_range(0, 255)));
                        end else begin
                            line.insert(line.size(), plain_byte());
                        end
                    end
                end
                5, 6, 7, 8: begin
                    closer = $urandom_range(0, 1) ? BYTE_QUOTE : BYTE_RBRACK;
                    line.insert(line.size(),
                                closer == BYTE_QUOTE ? BYTE_QUOTE : BYTE_LBRACK);
                    n = $urandom_range(0, 6);
                    repeat (n) begin
                        if ($urandom_range(0, 5) == 0) begin
                            line.insert(line.size(), BYTE_ESC);
                            line.insert(line.size(), noise_byte());
                        end else begin
                            do v = noise_byte(); while (v == closer || v == BYTE_ESC);
                            line.insert(line.size(), v);
                        end
                    end
                    line.insert(line.size(), closer);
                end
                default: begin
                    n = $urandom_range(1, 6);
                    repeat (n) line.insert(line.size(), noise_byte());
                end
            endcase
            // Leaving out the delimiter now and then puts an opener in mid-field.
            if (f < nf - 1 && $urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 2)) line.insert(line.size(), gen_delim);
        end
        // Some lines end early, often inside a span or right after an escape.
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, line.size());
            while (line.size() > cut) void'(line.pop_back());
        end
        idle_on = ($urandom_range(0, 3) != 0);
        foreach (line[i]) push_item(line[i], i == line.size() - 1);
    endtask

    logic [7:0] delim_set[9];

    initial begin
        int start;
        delim_set = '{8'h20, 8'h00, 8'hFF, BYTE_ESC, BYTE_QUOTE, BYTE_LBRACK,
                      BYTE_RBRACK, 8'h2C, 8'h00};
        delim_set[8] = 8'($urandom_range(0, 255));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines under the reset delimiter (space).
        push_item(8'h00, 1'b0);         // consecutive delimiters and byte extremes
        push_item(8'h20, 1'b0);
        push_item(8'h20, 1'b0);
        push_item(8'hFF, 1'b1);
        push_item(BYTE_QUOTE, 1'b0);    // empty quoted field still yields
        push_item(BYTE_QUOTE, 1'b0);
        push_item(8'h78, 1'b1);
        push_item(BYTE_LBRACK, 1'b0);   // delimiter inside a bracketed span
        push_item(8'h61, 1'b0);
        push_item(8'h20, 1'b0);
        push_item(BYTE_RBRACK, 1'b1);   // closer on the last byte, no second flush
        push_item(8'h61, 1'b0);         // opener in mid-field keeps the earlier content
        push_item(BYTE_QUOTE, 1'b0);
        push_item(8'h20, 1'b0);
        push_item(BYTE_QUOTE, 1'b1);
        push_item(BYTE_ESC, 1'b0);      // escaped quote, then a stray closer
        push_item(BYTE_QUOTE, 1'b0);
        push_item(BYTE_RBRACK, 1'b1);
        push_item(BYTE_QUOTE, 1'b0);    // other span's opener inside, unclosed at the end
        push_item(BYTE_LBRACK, 1'b0);
        push_item(8'h78, 1'b1);
        push_item(BYTE_LBRACK, 1'b1);   // empty unclosed span yields nothing
        push_item(8'h20, 1'b1);         // lone delimiter at the end
        push_item(BYTE_ESC, 1'b1);      // escape on the last byte
        wait_idle();

        // Random lines under a range of delimiters, special codes among them.
        foreach (delim_set[p]) begin
            write_delim(delim_set[p]);
            start = queued_count;
            while (queued_count - start < PHASE_ITEMS) queue_line();
            wait_idle();
        end

        if (tagged_q.size() != 0) begin
            mismatches++;
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, tagged_q.size());
        end
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
